// File: hdl/susb_pkg.sv
`default_nettype none
package susb_pkg;

  localparam int FACE_COUNT = 6;
  localparam int MAX_MIPS   = 16;

  localparam int GEN_W   = 64;
  localparam int FACE_W  = 3;
  localparam int FIDX_W  = 3;
  localparam int MIP_W   = 5;
  localparam int MIDX_W  = 4;
  localparam int STAGE_W = 3;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // item opcodes
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMMIT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FACES_PER_FRAME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIPS_PER_FRAME  = 1'b1;

  // stage codes as reported on stage_now
  localparam logic [STAGE_W-1:0] CODE_IDLE   = 3'd0;
  localparam logic [STAGE_W-1:0] CODE_FACES  = 3'd1;
  localparam logic [STAGE_W-1:0] CODE_SH     = 3'd2;
  localparam logic [STAGE_W-1:0] CODE_MIPS   = 3'd3;
  localparam logic [STAGE_W-1:0] CODE_COMMIT = 3'd4;
  localparam logic [STAGE_W-1:0] CODE_AWAIT  = 3'd5;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FACES  = 6'b000010,
    ST_SH     = 6'b000100,
    ST_MIPS   = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_AWAIT  = 6'b100000
  } stage_t;

  function automatic logic [STAGE_W-1:0] stage_code(input stage_t s);
    logic [STAGE_W-1:0] c;
    case (s)
      ST_IDLE:   c = CODE_IDLE;
      ST_FACES:  c = CODE_FACES;
      ST_SH:     c = CODE_SH;
      ST_MIPS:   c = CODE_MIPS;
      ST_COMMIT: c = CODE_COMMIT;
      ST_AWAIT:  c = CODE_AWAIT;
      default:   c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hdl/susb_if.sv
`default_nettype none
interface susb_req_if import susb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [GEN_W-1:0]  generation;
  logic              is_procedural_sky;
  logic [MIP_W-1:0]  mip_count;

  modport source (output valid, op, generation, is_procedural_sky, mip_count, input ready);
  modport sink   (input valid, op, generation, is_procedural_sky, mip_count, output ready);
endinterface

interface susb_res_if import susb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               error;
  logic [GEN_W-1:0]   plan_generation;
  logic [FIDX_W-1:0]  first_face;
  logic [FACE_W-1:0]  face_batch;
  logic               project_sh;
  logic [MIDX_W-1:0]  first_mip;
  logic [MIP_W-1:0]   mip_batch;
  logic               commit;
  logic [STAGE_W-1:0] stage_now;
  logic [GEN_W-1:0]   active_gen;
  logic               busy_res;

  modport source (output valid, accepted, error, plan_generation, first_face, face_batch,
                  project_sh, first_mip, mip_batch, commit, stage_now, active_gen, busy_res,
                  input ready);
  modport sink   (input valid, accepted, error, plan_generation, first_face, face_batch,
                  project_sh, first_mip, mip_batch, commit, stage_now, active_gen, busy_res,
                  output ready);
endinterface

interface susb_cfg_if import susb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/staged_update_budget_sequencer.sv
// Staged update budget sequencer.
// req carries one item per handshake: a request (generation, procedural
// flag, mip count), a frame tick, or a commit completion. res returns
// exactly one result item per accepted req item: accept/error flags, the
// tick's plan (face batch, harmonics step, mip batch, commit) and status.
// cfg writes faces_per_frame (index 0) and mips_per_frame (index 1); it is
// always ready and takes effect on the next req item.
// The result appears in the output register in the cycle after the req
// item is accepted. Throughput: one item per cycle unless res stalls, set
// by the single state update path between the job registers and the
// output register. req.ready is high while the output register is empty
// or being drained, so a stalled receiver holds res and blocks new items.
// Reset (rst, synchronous) returns the job to idle, clears pending and
// active generations, sets both budgets to 1 and empties the output.
`default_nettype none
module staged_update_budget_sequencer import susb_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  susb_req_if.sink    req,
  susb_res_if.source  res,
  susb_cfg_if.sink    cfg
);

  logic [FACE_W-1:0] faces_per_frame;
  logic [MIP_W-1:0]  mips_per_frame;

  stage_t            stage, stage_next;
  logic              in_progress, in_progress_next;
  logic [GEN_W-1:0]  pending_gen, pending_gen_next;
  logic [GEN_W-1:0]  committed_gen, committed_gen_next;
  logic [FIDX_W-1:0] face_cursor, face_cursor_next;
  logic [FACE_W-1:0] face_total, face_total_next;
  logic [MIP_W-1:0]  mip_cursor, mip_cursor_next;
  logic [MIP_W-1:0]  mip_total, mip_total_next;

  logic [FACE_W-1:0] fb, face_rem;
  logic [MIP_W-1:0]  mb, mip_rem;

  logic              r_accepted, r_error, r_project_sh, r_commit;
  logic [FIDX_W-1:0] r_first_face;
  logic [FACE_W-1:0] r_face_batch;
  logic [MIDX_W-1:0] r_first_mip;
  logic [MIP_W-1:0]  r_mip_batch;

  logic              res_valid;
  logic              accepted_q, error_q, project_sh_q, commit_q, busy_q;
  logic [GEN_W-1:0]  plan_gen_q, active_gen_q;
  logic [FIDX_W-1:0] first_face_q;
  logic [FACE_W-1:0] face_batch_q;
  logic [MIDX_W-1:0] first_mip_q;
  logic [MIP_W-1:0]  mip_batch_q;
  logic [STAGE_W-1:0] stage_now_q;

  logic take;

  assign cfg.ready = 1'b1;
  assign req.ready = !res_valid || res.ready;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      faces_per_frame <= FACE_W'(1);
      mips_per_frame  <= MIP_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FACES_PER_FRAME: faces_per_frame <= cfg.data[FACE_W-1:0];
        CFG_MIPS_PER_FRAME:  mips_per_frame  <= cfg.data[MIP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero budgets count as one so a job always advances
  assign fb       = (faces_per_frame == '0) ? FACE_W'(1) : faces_per_frame;
  assign mb       = (mips_per_frame == '0) ? MIP_W'(1) : mips_per_frame;
  assign face_rem = face_total - face_cursor;
  assign mip_rem  = mip_total - mip_cursor;

  always_comb begin
    stage_next         = stage;
    in_progress_next   = in_progress;
    pending_gen_next   = pending_gen;
    committed_gen_next = committed_gen;
    face_cursor_next   = face_cursor;
    face_total_next    = face_total;
    mip_cursor_next    = mip_cursor;
    mip_total_next     = mip_total;
    r_accepted   = 1'b0;
    r_error      = 1'b0;
    r_first_face = '0;
    r_face_batch = '0;
    r_project_sh = 1'b0;
    r_first_mip  = '0;
    r_mip_batch  = '0;
    r_commit     = 1'b0;
    case (req.op)
      OP_REQUEST: begin
        if (req.mip_count == '0) begin
          r_error = 1'b1;
        end else if (!(in_progress && req.generation == pending_gen)) begin
          pending_gen_next = req.generation;
          face_cursor_next = '0;
          face_total_next  = req.is_procedural_sky ? FACE_W'(FACE_COUNT) : '0;
          mip_cursor_next  = '0;
          mip_total_next   = (req.mip_count > MIP_W'(MAX_MIPS)) ? MIP_W'(MAX_MIPS)
                                                                : req.mip_count;
          stage_next       = req.is_procedural_sky ? ST_FACES : ST_SH;
          in_progress_next = 1'b1;
          r_accepted       = 1'b1;
        end
      end
      OP_TICK: begin
        // finished stages fall through to the next one within the same tick
        if (in_progress) begin
          if (stage_next == ST_FACES) begin
            r_face_batch = (fb < face_rem) ? fb : face_rem;
            if (r_face_batch != '0) r_first_face = face_cursor;
            face_cursor_next = face_cursor + r_face_batch;
            if (face_cursor_next == face_total) stage_next = ST_SH;
          end
          if (stage_next == ST_SH) begin
            r_project_sh = 1'b1;
            stage_next   = ST_MIPS;
          end
          if (stage_next == ST_MIPS) begin
            r_mip_batch = (mb < mip_rem) ? mb : mip_rem;
            if (r_mip_batch != '0) r_first_mip = mip_cursor[MIDX_W-1:0];
            mip_cursor_next = mip_cursor + r_mip_batch;
            if (mip_cursor_next == mip_total) stage_next = ST_COMMIT;
          end
          if (stage_next == ST_COMMIT) begin
            r_commit   = 1'b1;
            stage_next = ST_AWAIT;
          end
        end
      end
      OP_COMMIT: begin
        if (!in_progress || stage != ST_AWAIT || req.generation != pending_gen) begin
          r_error = 1'b1;
        end else begin
          committed_gen_next = req.generation;
          stage_next         = ST_IDLE;
          in_progress_next   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= ST_IDLE;
      in_progress   <= 1'b0;
      pending_gen   <= '0;
      committed_gen <= '0;
      face_cursor   <= '0;
      face_total    <= '0;
      mip_cursor    <= '0;
      mip_total     <= '0;
    end else if (take) begin
      stage         <= stage_next;
      in_progress   <= in_progress_next;
      pending_gen   <= pending_gen_next;
      committed_gen <= committed_gen_next;
      face_cursor   <= face_cursor_next;
      face_total    <= face_total_next;
      mip_cursor    <= mip_cursor_next;
      mip_total     <= mip_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accepted_q   <= r_accepted;
      error_q      <= r_error;
      plan_gen_q   <= in_progress_next ? pending_gen_next : '0;
      first_face_q <= r_first_face;
      face_batch_q <= r_face_batch;
      project_sh_q <= r_project_sh;
      first_mip_q  <= r_first_mip;
      mip_batch_q  <= r_mip_batch;
      commit_q     <= r_commit;
      stage_now_q  <= stage_code(stage_next);
      active_gen_q <= committed_gen_next;
      busy_q       <= in_progress_next;
    end
  end

  assign res.valid           = res_valid;
  assign res.accepted        = accepted_q;
  assign res.error           = error_q;
  assign res.plan_generation = plan_gen_q;
  assign res.first_face      = first_face_q;
  assign res.face_batch      = face_batch_q;
  assign res.project_sh      = project_sh_q;
  assign res.first_mip       = first_mip_q;
  assign res.mip_batch       = mip_batch_q;
  assign res.commit          = commit_q;
  assign res.stage_now       = stage_now_q;
  assign res.active_gen      = active_gen_q;
  assign res.busy_res        = busy_q;

  a_idle_matches_progress: assert property (@(posedge clk) disable iff (rst)
    (stage == ST_IDLE) == !in_progress)
    else $error("stage and in_progress disagree");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    in_progress |-> (mip_cursor <= mip_total && face_cursor <= face_total))
    else $error("cursor past its total");

  a_commit_awaits: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.commit |-> res.stage_now == CODE_AWAIT && res.busy_res)
    else $error("commit planned without awaiting stage");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.accepted |-> res.busy_res && !res.error)
    else $error("accepted request left no job in progress");

  a_zero_mip_holds: assert property (@(posedge clk) disable iff (rst)
    take && req.op == OP_REQUEST && req.mip_count == '0 |=>
      $stable(pending_gen) && $stable(stage))
    else $error("zero mip request changed the job");

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb import susb_pkg::*; ();

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [GEN_W-1:0] GEN_MAX = '1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 108;
  localparam int N_DIRECTED = 23;
  localparam int N_FIELDS = 12;
  // budget data per phase; 0 is treated as 1, faces keep only the low 3 bits
  localparam int FACE_SET [PHASES] = '{6, 1, 0, 7, 13, 2, 5, 4, 6, 1, 3, 6};
  localparam int MIP_SET [PHASES] = '{16, 1, 0, 31, 5, 8, 3, 16, 2, 7, 1, 12};

  typedef struct {
    logic               accepted;
    logic               error;
    logic [GEN_W-1:0]   plan_generation;
    logic [FIDX_W-1:0]  first_face;
    logic [FACE_W-1:0]  face_batch;
    logic               project_sh;
    logic [MIDX_W-1:0]  first_mip;
    logic [MIP_W-1:0]   mip_batch;
    logic               commit;
    logic [STAGE_W-1:0] stage_now;
    logic [GEN_W-1:0]   active_gen;
    logic               busy_res;
  } plan_t;

  typedef logic [GEN_W-1:0] field_vec_t [N_FIELDS];

  typedef struct {
    plan_t plan;
    bit    pinned;
    plan_t pin;
  } outcome_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [GEN_W-1:0]   gen;
    logic               proc;
    logic [MIP_W-1:0]   mips;
    bit                 pinned;
    logic               acc;
    logic               err;
    logic [STAGE_W-1:0] stage;
    logic               busy;
  } stim_row_t;

  logic clk;
  logic rst;

  susb_req_if req ();
  susb_res_if res ();
  susb_cfg_if cfg ();

  staged_update_budget_sequencer dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .cfg(cfg)
  );

  // job predictor state
  logic [STAGE_W-1:0] job_stage;
  logic               job_busy;
  logic [GEN_W-1:0]   pend_gen;
  logic [GEN_W-1:0]   live_gen;
  logic [FIDX_W-1:0]  face_cur;
  logic [FIDX_W-1:0]  face_tot;
  logic [MIP_W-1:0]   mip_cur;
  logic [MIP_W-1:0]   mip_tot;
  logic [2:0]         face_budget;
  logic [4:0]         mip_budget;

  outcome_t  outcome_q [$];
  outcome_t  due;
  plan_t     seen;
  field_vec_t got_v;
  field_vec_t want_v;
  field_vec_t pin_v;
  stim_row_t directed_rows [N_DIRECTED];

  int tx_idle_pct;
  int rx_idle_pct;
  int holds_asked;
  int holds_seen;
  int hold_left;
  int cycles;
  int mismatches;
  int results_checked;
  int items_sent;
  int n_req, n_tick, n_commit, n_other;
  int jobs_done;
  int budget_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic plan_t advance_job(input logic [OP_W-1:0] op, input logic [GEN_W-1:0] gen,
                                        input logic proc, input logic [MIP_W-1:0] mreq);
    plan_t p;
    int fb, mb, n;
    p = '{default: '0};
    case (op)
      OP_REQUEST: begin
        if (mreq == '0) begin
          p.error = 1'b1;
        end else if (!(job_busy && gen == pend_gen)) begin
          pend_gen = gen;
          face_cur = '0;
          face_tot = proc ? FIDX_W'(FACE_COUNT) : '0;
          mip_cur = '0;
          mip_tot = (mreq > MIP_W'(MAX_MIPS)) ? MIP_W'(MAX_MIPS) : mreq;
          job_stage = proc ? CODE_FACES : CODE_SH;
          job_busy = 1'b1;
          p.accepted = 1'b1;
        end
      end
      OP_TICK: begin
        if (job_busy) begin
          fb = (face_budget == '0) ? 1 : int'(face_budget);
          mb = (mip_budget == '0) ? 1 : int'(mip_budget);
          // stages that finish in this tick hand over to the next one at once
          if (job_stage == CODE_FACES) begin
            n = int'(face_tot) - int'(face_cur);
            if (fb < n) n = fb;
            p.face_batch = FACE_W'(n);
            if (n > 0) p.first_face = face_cur;
            face_cur = face_cur + FIDX_W'(n);
            if (face_cur == face_tot) job_stage = CODE_SH;
          end
          if (job_stage == CODE_SH) begin
            p.project_sh = 1'b1;
            job_stage = CODE_MIPS;
          end
          if (job_stage == CODE_MIPS) begin
            n = int'(mip_tot) - int'(mip_cur);
            if (mb < n) n = mb;
            p.mip_batch = MIP_W'(n);
            if (n > 0) p.first_mip = MIDX_W'(mip_cur);
            mip_cur = mip_cur + MIP_W'(n);
            if (mip_cur == mip_tot) job_stage = CODE_COMMIT;
          end
          if (job_stage == CODE_COMMIT) begin
            p.commit = 1'b1;
            job_stage = CODE_AWAIT;
          end
        end
      end
      OP_COMMIT: begin
        if (!job_busy || job_stage != CODE_AWAIT || gen != pend_gen) begin
          p.error = 1'b1;
        end else begin
          live_gen = gen;
          job_stage = CODE_IDLE;
          job_busy = 1'b0;
          jobs_done++;
        end
      end
      default: ;
    endcase
    p.plan_generation = job_busy ? pend_gen : '0;
    p.stage_now = job_stage;
    p.active_gen = live_gen;
    p.busy_res = job_busy;
    return p;
  endfunction

  function automatic field_vec_t flatten(input plan_t p);
    field_vec_t v;
    v[0]  = 64'(p.accepted);
    v[1]  = 64'(p.error);
    v[2]  = p.plan_generation;
    v[3]  = 64'(p.first_face);
    v[4]  = 64'(p.face_batch);
    v[5]  = 64'(p.project_sh);
    v[6]  = 64'(p.first_mip);
    v[7]  = 64'(p.mip_batch);
    v[8]  = 64'(p.commit);
    v[9]  = 64'(p.stage_now);
    v[10] = p.active_gen;
    v[11] = 64'(p.busy_res);
    return v;
  endfunction

  function automatic string field_name(input int i);
    case (i)
      0: return "accepted";
      1: return "error";
      2: return "plan_generation";
      3: return "first_face";
      4: return "face_batch";
      5: return "project_sh";
      6: return "first_mip";
      7: return "mip_batch";
      8: return "commit";
      9: return "stage_now";
      10: return "active_gen";
      default: return "busy_res";
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [GEN_W-1:0] got,
                                 input logic [GEN_W-1:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH @%0d result %0d: %s got %0h want %0h", cycles, results_checked, what,
               got, want);
  endtask

  function automatic stim_row_t make_row(input logic [OP_W-1:0] op, input logic [GEN_W-1:0] gen,
                                         input logic proc, input logic [MIP_W-1:0] mips);
    stim_row_t r;
    r = '{default: '0};
    r.op = op;
    r.gen = gen;
    r.proc = proc;
    r.mips = mips;
    return r;
  endfunction

  function automatic logic [GEN_W-1:0] pick_gen();
    case ($urandom_range(7))
      0, 1: return GEN_W'($urandom_range(3));
      2: return pend_gen;
      3: return live_gen;
      4: return GEN_MAX;
      5: return GEN_W'(1) << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(input stim_row_t row);
    outcome_t o;
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= row.op;
    req.generation <= row.gen;
    req.is_procedural_sky <= row.proc;
    req.mip_count <= row.mips;
    do @(posedge clk); while (req.ready !== 1'b1);
    o.plan = advance_job(row.op, row.gen, row.proc, row.mips);
    o.pinned = row.pinned;
    o.pin = '{default: '0};
    o.pin.accepted = row.acc;
    o.pin.error = row.err;
    o.pin.stage_now = row.stage;
    o.pin.busy_res = row.busy;
    outcome_q.insert(outcome_q.size(), o);
    items_sent++;
    case (row.op)
      OP_REQUEST: n_req++;
      OP_TICK: n_tick++;
      OP_COMMIT: n_commit++;
      default: n_other++;
    endcase
  endtask

  task automatic write_budget(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= CFG_DATA_W'(value);
    do @(posedge clk); while (cfg.ready !== 1'b1);
    if (idx == CFG_FACES_PER_FRAME) face_budget = 3'(value);
    else mip_budget = 5'(value);
    budget_writes++;
  endtask

  // stop offering items and wait until every outstanding result is back
  task automatic settle();
    req.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one job: request, ticks up to the commit, then the completion, with some noise
  task automatic run_job();
    int guard;
    logic [MIP_W-1:0] m;
    if ($urandom_range(99) < 15) begin
      send_item(make_row(OP_W'($urandom_range(3)), pick_gen(), 1'($urandom_range(1)),
                         MIP_W'($urandom_range(31))));
      return;
    end
    m = ($urandom_range(99) < 88) ? MIP_W'($urandom_range(16, 1)) : MIP_W'($urandom_range(31));
    send_item(make_row(OP_REQUEST, pick_gen(), 1'($urandom_range(1)), m));
    guard = 0;
    while (job_busy && job_stage != CODE_AWAIT && guard < 48) begin
      guard++;
      case ($urandom_range(49))
        0: send_item(make_row(OP_COMMIT, pend_gen, 1'($urandom_range(1)),
                              MIP_W'($urandom_range(31))));
        1: send_item(make_row(OP_REQUEST, $urandom_range(1) ? pend_gen : pick_gen(),
                              1'($urandom_range(1)), MIP_W'($urandom_range(16, 1))));
        default: send_item(make_row(OP_TICK, {$urandom, $urandom}, 1'($urandom_range(1)),
                                    MIP_W'($urandom_range(31))));
      endcase
    end
    if ($urandom_range(99) < 25)
      send_item(make_row(OP_TICK, {$urandom, $urandom}, 1'($urandom_range(1)),
                         MIP_W'($urandom_range(31))));
    send_item(make_row(OP_COMMIT, ($urandom_range(99) < 85) ? pend_gen : pick_gen(),
                       1'($urandom_range(1)), MIP_W'($urandom_range(31))));
  endtask

  // result receiver: random stalls plus the occasional long hold-off
  initial begin
    res.ready = 1'b0;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res.ready <= 1'b0;
      end else if (hold_left != 0) begin
        res.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (holds_seen != holds_asked) begin
        res.ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        holds_seen = holds_asked;
      end else begin
        res.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      seen.accepted = res.accepted;
      seen.error = res.error;
      seen.plan_generation = res.plan_generation;
      seen.first_face = res.first_face;
      seen.face_batch = res.face_batch;
      seen.project_sh = res.project_sh;
      seen.first_mip = res.first_mip;
      seen.mip_batch = res.mip_batch;
      seen.commit = res.commit;
      seen.stage_now = res.stage_now;
      seen.active_gen = res.active_gen;
      seen.busy_res = res.busy_res;
      if (outcome_q.size() == 0) begin
        report_mismatch("result item with no item outstanding", '0, '0);
      end else begin
        due = outcome_q.pop_front();
        got_v = flatten(seen);
        want_v = flatten(due.plan);
        pin_v = flatten(due.pin);
        for (int i = 0; i < N_FIELDS; i++) begin
          if (got_v[i] !== want_v[i])
            report_mismatch(field_name(i), got_v[i], want_v[i]);
          // directed rows also carry hand-written status values
          if (due.pinned && (i == 0 || i == 1 || i == 9 || i == 11) &&
              got_v[i] !== pin_v[i])
            report_mismatch({field_name(i), " (directed)"}, got_v[i], pin_v[i]);
        end
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, outcome_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int ph_base;
    bit pressed;
    rst = 1'b1;
    req.valid = 1'b0;
    req.op = OP_TICK;
    req.generation = '0;
    req.is_procedural_sky = 1'b0;
    req.mip_count = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_FACES_PER_FRAME;
    cfg.data = '0;
    cycles = 0;
    mismatches = 0;
    results_checked = 0;
    items_sent = 0;
    n_req = 0;
    n_tick = 0;
    n_commit = 0;
    n_other = 0;
    jobs_done = 0;
    budget_writes = 0;
    holds_asked = 0;
    job_stage = CODE_IDLE;
    job_busy = 1'b0;
    pend_gen = '0;
    live_gen = '0;
    face_cur = '0;
    face_tot = '0;
    mip_cur = '0;
    mip_tot = '0;
    face_budget = 3'd1;
    mip_budget = 5'd1;
    tx_idle_pct = 18;
    rx_idle_pct = 45;

    // op, generation, procedural, mips | pinned, accepted, error, stage, busy
    directed_rows = '{
      '{OP_TICK,    '0,      1'b0, 5'd0,  1'b1, 1'b0, 1'b0, CODE_IDLE,  1'b0},
      '{OP_COMMIT,  '0,      1'b0, 5'd0,  1'b1, 1'b0, 1'b1, CODE_IDLE,  1'b0},
      '{OP_REQUEST, 64'd5,   1'b1, 5'd0,  1'b1, 1'b0, 1'b1, CODE_IDLE,  1'b0},
      '{OP_UNUSED,  GEN_MAX, 1'b1, 5'd31, 1'b1, 1'b0, 1'b0, CODE_IDLE,  1'b0},
      '{OP_REQUEST, GEN_MAX, 1'b1, 5'd31, 1'b1, 1'b1, 1'b0, CODE_FACES, 1'b1},
      '{OP_REQUEST, GEN_MAX, 1'b1, 5'd31, 1'b1, 1'b0, 1'b0, CODE_FACES, 1'b1},
      '{OP_COMMIT,  GEN_MAX, 1'b0, 5'd0,  1'b1, 1'b0, 1'b1, CODE_FACES, 1'b1},
      '{OP_REQUEST, GEN_MAX, 1'b0, 5'd0,  1'b1, 1'b0, 1'b1, CODE_FACES, 1'b1},
      '{OP_TICK,    '0,      1'b0, 5'd0,  1'b0, 1'b0, 1'b0, CODE_IDLE,  1'b0},
      '{OP_TICK,    GEN_MAX, 1'b1, 5'd31, 1'b0, 1'b0, 1'b0, CODE_IDLE,  1'b0},
      '{OP_TICK,    '0,      1'b0, 5'd0,  1'b0, 1'b0, 1'b0, CODE_IDLE,  1'b0},
      '{OP_TICK,    '0,      1'b0, 5'd0,  1'b0, 1'b0, 1'b0, CODE_IDLE,  1'b0},
      '{OP_TICK,    '0,      1'b0, 5'd0,  1'b0, 1'b0, 1'b0, CODE_IDLE,  1'b0},
      '{OP_TICK,    '0,      1'b0, 5'd0,  1'b0, 1'b0, 1'b0, CODE_IDLE,  1'b0},
      '{OP_TICK,    '0,      1'b0, 5'd0,  1'b0, 1'b0, 1'b0, CODE_IDLE,  1'b0},
      '{OP_REQUEST, '0,      1'b0, 5'd1,  1'b1, 1'b1, 1'b0, CODE_SH,    1'b1},
      '{OP_TICK,    '0,      1'b0, 5'd0,  1'b1, 1'b0, 1'b0, CODE_AWAIT, 1'b1},
      '{OP_TICK,    '0,      1'b0, 5'd0,  1'b1, 1'b0, 1'b0, CODE_AWAIT, 1'b1},
      '{OP_COMMIT,  64'd1,   1'b0, 5'd0,  1'b1, 1'b0, 1'b1, CODE_AWAIT, 1'b1},
      '{OP_REQUEST, '0,      1'b1, 5'd3,  1'b1, 1'b0, 1'b0, CODE_AWAIT, 1'b1},
      '{OP_COMMIT,  '0,      1'b0, 5'd0,  1'b1, 1'b0, 1'b0, CODE_IDLE,  1'b0},
      '{OP_REQUEST, '0,      1'b1, 5'd16, 1'b1, 1'b1, 1'b0, CODE_FACES, 1'b1},
      '{OP_COMMIT,  '0,      1'b0, 5'd0,  1'b1, 1'b0, 1'b1, CODE_FACES, 1'b1}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(directed_rows[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      tx_idle_pct = (ph < 4) ? 18 : (ph < 8) ? 45 : 0;
      rx_idle_pct <= (ph < 4) ? 45 : (ph < 8) ? 18 : 0;
      write_budget(CFG_FACES_PER_FRAME, FACE_SET[ph]);
      write_budget(CFG_MIPS_PER_FRAME, MIP_SET[ph]);
      cfg.valid <= 1'b0;
      ph_base = items_sent;
      pressed = 1'b0;
      while (items_sent - ph_base < PHASE_ITEMS) begin
        if (!pressed && items_sent - ph_base >= 40) begin
          pressed = 1'b1;
          // receiver holds off while items keep coming, so the input backs up
          if (ph == 1 || ph == 9) holds_asked <= holds_asked + 1;
          // sender pauses until the block has returned everything
          if (ph == 6) settle();
        end
        run_job();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d items: %0d requests, %0d frame ticks, %0d commit completions,",
             items_sent, n_req, n_tick, n_commit);
    $display("%0d unused ops, %0d jobs committed, %0d budget writes, %0d receiver hold-offs",
             n_other, jobs_done, budget_writes, holds_asked);
    $display("%0d results checked", results_checked);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/susb_pkg.sv
hdl/susb_if.sv
hdl/staged_update_budget_sequencer.sv
verif/tb.sv
